FILE: sv/ptca_pkg.sv
// Shared types and constants for the process-table common-ancestor block.
// Used by the controller, the datapath, the top level and the checker; no dependencies.
`default_nettype none

package ptca_pkg;

    localparam int unsigned DEPTH  = 256;
    localparam int unsigned IDX_W  = $clog2(DEPTH);
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned PID_W  = 15;
    localparam int unsigned PAR_W  = 8;
    localparam int unsigned SLOT_W = 8;
    localparam int unsigned STS_W  = 3;
    localparam int unsigned CMP_W  = (CNT_W > PAR_W) ? CNT_W : PAR_W;
    localparam int unsigned IN_W   = 64;
    localparam int unsigned OUT_W  = 24;
    localparam int unsigned OUT_PAD = OUT_W - STS_W - PID_W;

    typedef logic [STS_W-1:0] t_status;

    localparam t_status STS_FOUND   = 3'd0;
    localparam t_status STS_MISSING = 3'd1;
    localparam t_status STS_ROOT    = 3'd2;
    localparam t_status STS_DIFFER  = 3'd3;
    localparam t_status STS_LONG    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_WALK1_GO,
        S_WALK1,
        S_WALK2_GO,
        S_WALK2,
        S_CMP_GO,
        S_CMP,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RD_SCAN,
        RD_START,
        RD_PARENT
    } t_rd_sel;

    typedef enum logic [1:0] {
        WK_MOVE,
        WK_ROOT,
        WK_MISSING,
        WK_LONG
    } t_walk_res;

    typedef struct packed {
        logic      wr_entry;
        logic      load_query;
        logic      scan_step;
        logic      walk_start;
        logic      walk_step;
        logic      walk_sel;
        t_rd_sel   rd_sel;
        logic      cmp_start;
        logic      cmp_step;
        logic      set_status;
        t_status   status_code;
    } t_cmd;

    typedef struct packed {
        logic      scan_done;
        logic      found_both;
        t_walk_res walk_res;
        logic      root_case;
        logic      cmp_diff;
        logic      cmp_more;
    } t_sts;

endpackage

`default_nettype wire

FILE: sv/process_table_common_ancestor.sv
// A query scans the table, walks both parent chains and compares them from the root end;
// a missing pid ends the query after the scan.
// Items are taken one at a time: the table scan and the single table read port set the pace,
// and the result waits in its register until taken.
// Reset: synchronous, active low; clears the controller and all in-use flags.
`default_nettype none

module process_table_common_ancestor (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // entry_index, entry_pid, entry_parent, entry_in_use, first_pid, second_pid, zero pad
    input  logic [ptca_pkg::IN_W-1:0]  s_axis_tdata,
    // action
    input  logic                       s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // status, ancestor_pid, zero pad
    output logic [ptca_pkg::OUT_W-1:0] m_axis_tdata
);

    ptca_pkg::t_cmd             cmd;
    ptca_pkg::t_sts             sts;
    ptca_pkg::t_status          status;
    logic [ptca_pkg::PID_W-1:0] ancestor_pid;

    ptca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_action (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    ptca_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_entry_index  (s_axis_tdata[7:0]),
        .i_entry_pid    (s_axis_tdata[22:8]),
        .i_entry_parent (s_axis_tdata[30:23]),
        .i_entry_in_use (s_axis_tdata[31]),
        .i_first_pid    (s_axis_tdata[46:32]),
        .i_second_pid   (s_axis_tdata[61:47]),
        .o_status       (status),
        .o_ancestor_pid (ancestor_pid)
    );

    assign m_axis_tdata = {{ptca_pkg::OUT_PAD{1'b0}}, ancestor_pid, status};

endmodule

`default_nettype wire

FILE: sv/ptca_ctrl.sv
// Controller state machine for the process-table common-ancestor block.
// Depends on ptca_pkg; drives commands to ptca_dp and reads its status.
`default_nettype none

module ptca_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_action,
    input  logic            i_out_ready,
    input  ptca_pkg::t_sts  i_sts,
    output ptca_pkg::t_cmd  o_cmd,
    output logic            o_in_ready,
    output logic            o_out_valid
);

    ptca_pkg::t_state r_state;
    ptca_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptca_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptca_pkg::S_IDLE: begin
                if (i_in_valid && i_in_action) begin
                    n_state = ptca_pkg::S_SCAN;
                end
            end
            ptca_pkg::S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = i_sts.found_both ? ptca_pkg::S_WALK1_GO : ptca_pkg::S_DONE;
                end
            end
            ptca_pkg::S_WALK1_GO: n_state = ptca_pkg::S_WALK1;
            ptca_pkg::S_WALK1: begin
                if (i_sts.walk_res == ptca_pkg::WK_ROOT) begin
                    n_state = ptca_pkg::S_WALK2_GO;
                end else if (i_sts.walk_res != ptca_pkg::WK_MOVE) begin
                    n_state = ptca_pkg::S_DONE;
                end
            end
            ptca_pkg::S_WALK2_GO: n_state = ptca_pkg::S_WALK2;
            ptca_pkg::S_WALK2: begin
                if (i_sts.walk_res == ptca_pkg::WK_ROOT) begin
                    n_state = ptca_pkg::S_CMP_GO;
                end else if (i_sts.walk_res != ptca_pkg::WK_MOVE) begin
                    n_state = ptca_pkg::S_DONE;
                end
            end
            ptca_pkg::S_CMP_GO: begin
                n_state = i_sts.root_case ? ptca_pkg::S_DONE : ptca_pkg::S_CMP;
            end
            ptca_pkg::S_CMP: begin
                if (i_sts.cmp_diff || !i_sts.cmp_more) begin
                    n_state = ptca_pkg::S_DONE;
                end
            end
            ptca_pkg::S_DONE: begin
                if (i_out_ready) begin
                    n_state = ptca_pkg::S_IDLE;
                end
            end
            default: n_state = ptca_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state) inside
            ptca_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_query = i_in_action;
                    o_cmd.wr_entry   = !i_in_action;
                end
            end
            ptca_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.rd_sel    = ptca_pkg::RD_SCAN;
                if (i_sts.scan_done && !i_sts.found_both) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ptca_pkg::STS_MISSING;
                end
            end
            ptca_pkg::S_WALK1_GO, ptca_pkg::S_WALK2_GO: begin
                o_cmd.walk_start = 1'b1;
                o_cmd.walk_sel   = (r_state == ptca_pkg::S_WALK2_GO);
                o_cmd.rd_sel     = ptca_pkg::RD_START;
            end
            ptca_pkg::S_WALK1, ptca_pkg::S_WALK2: begin
                o_cmd.walk_step = 1'b1;
                o_cmd.walk_sel  = (r_state == ptca_pkg::S_WALK2);
                o_cmd.rd_sel    = ptca_pkg::RD_PARENT;
                if (i_sts.walk_res == ptca_pkg::WK_MISSING) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ptca_pkg::STS_MISSING;
                end else if (i_sts.walk_res == ptca_pkg::WK_LONG) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ptca_pkg::STS_LONG;
                end
            end
            ptca_pkg::S_CMP_GO: begin
                if (i_sts.root_case) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ptca_pkg::STS_ROOT;
                end else begin
                    o_cmd.cmp_start = 1'b1;
                end
            end
            ptca_pkg::S_CMP: begin
                o_cmd.cmp_step = 1'b1;
                if (i_sts.cmp_diff) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ptca_pkg::STS_DIFFER;
                end else if (!i_sts.cmp_more) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ptca_pkg::STS_FOUND;
                end
            end
            ptca_pkg::S_DONE: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/ptca_dp.sv
// Datapath for the process-table common-ancestor block: table memory, in-use
// flags, chain memories, scan and walk counters and the result registers.
// Depends on ptca_pkg; commanded by ptca_ctrl.
`default_nettype none

module ptca_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ptca_pkg::t_cmd              i_cmd,
    output ptca_pkg::t_sts              o_sts,
    input  logic [ptca_pkg::SLOT_W-1:0] i_entry_index,
    input  logic [ptca_pkg::PID_W-1:0]  i_entry_pid,
    input  logic [ptca_pkg::PAR_W-1:0]  i_entry_parent,
    input  logic                        i_entry_in_use,
    input  logic [ptca_pkg::PID_W-1:0]  i_first_pid,
    input  logic [ptca_pkg::PID_W-1:0]  i_second_pid,
    output ptca_pkg::t_status           o_status,
    output logic [ptca_pkg::PID_W-1:0]  o_ancestor_pid
);

    logic [ptca_pkg::PID_W-1:0] r_slot_pid    [ptca_pkg::DEPTH];
    logic [ptca_pkg::PAR_W-1:0] r_slot_parent [ptca_pkg::DEPTH];
    logic [ptca_pkg::DEPTH-1:0] r_slot_live;
    logic [ptca_pkg::PID_W-1:0] r_first_path  [ptca_pkg::DEPTH];
    logic [ptca_pkg::PID_W-1:0] r_second_path [ptca_pkg::DEPTH];

    logic [ptca_pkg::PID_W-1:0] r_rd_pid;
    logic [ptca_pkg::PAR_W-1:0] r_rd_par;
    logic                       r_rd_live;
    logic [ptca_pkg::PID_W-1:0] r_p1;
    logic [ptca_pkg::PID_W-1:0] r_p2;

    logic [ptca_pkg::PID_W-1:0] r_q1;
    logic [ptca_pkg::PID_W-1:0] r_q2;
    logic [ptca_pkg::CNT_W-1:0] r_cnt;
    logic                       r_f1;
    logic                       r_f2;
    logic [ptca_pkg::IDX_W-1:0] r_s1;
    logic [ptca_pkg::IDX_W-1:0] r_s2;
    logic [ptca_pkg::IDX_W-1:0] r_cur;
    logic                       r_first;
    logic [ptca_pkg::CNT_W-1:0] r_n;
    logic [ptca_pkg::CNT_W-1:0] r_n1;
    logic [ptca_pkg::CNT_W-1:0] r_n2;
    logic [ptca_pkg::IDX_W-1:0] r_k1;
    logic [ptca_pkg::IDX_W-1:0] r_k2;
    logic                       r_cfirst;
    logic [ptca_pkg::PID_W-1:0] r_anc;
    ptca_pkg::t_status          r_status;

    logic [ptca_pkg::CMP_W-1:0] wr_idx_w;
    logic [ptca_pkg::IDX_W-1:0] wr_addr;
    logic                       wr_ok;
    logic [ptca_pkg::IDX_W-1:0] rd_addr;
    logic [ptca_pkg::CNT_W-1:0] cnt_m1;
    logic [ptca_pkg::IDX_W-1:0] ev_idx;
    logic                       hit1;
    logic                       hit2;
    logic                       n_f1;
    logic                       n_f2;
    logic [ptca_pkg::CMP_W-1:0] par_w;
    logic [ptca_pkg::CMP_W-1:0] cur_w;
    logic [ptca_pkg::CNT_W-1:0] n_eff;
    ptca_pkg::t_walk_res        walk_res;
    logic [ptca_pkg::CNT_W-1:0] n1_m1;
    logic [ptca_pkg::CNT_W-1:0] n2_m1;
    logic [ptca_pkg::IDX_W-1:0] k1_m1;
    logic [ptca_pkg::IDX_W-1:0] k2_m1;
    logic [ptca_pkg::IDX_W-1:0] p1_addr;
    logic [ptca_pkg::IDX_W-1:0] p2_addr;
    logic                       cmp_eq;

    assign wr_idx_w = ptca_pkg::CMP_W'(i_entry_index);
    assign wr_addr  = wr_idx_w[ptca_pkg::IDX_W-1:0];
    assign wr_ok    = wr_idx_w < ptca_pkg::CMP_W'(ptca_pkg::DEPTH);

    assign cnt_m1 = r_cnt - 1'b1;
    assign ev_idx = cnt_m1[ptca_pkg::IDX_W-1:0];
    assign hit1   = (r_cnt != '0) && r_rd_live && (r_rd_pid == r_q1);
    assign hit2   = (r_cnt != '0) && r_rd_live && (r_rd_pid == r_q2);
    assign n_f1   = r_f1 | hit1;
    assign n_f2   = r_f2 | hit2;

    assign par_w = ptca_pkg::CMP_W'(r_rd_par);
    assign cur_w = ptca_pkg::CMP_W'(r_cur);
    assign n_eff = r_first ? '0 : r_n + 1'b1;

    always_comb begin
        if (par_w == cur_w) begin
            walk_res = ptca_pkg::WK_ROOT;
        end else if (par_w >= ptca_pkg::CMP_W'(ptca_pkg::DEPTH)) begin
            walk_res = ptca_pkg::WK_MISSING;
        end else if (n_eff >= ptca_pkg::CNT_W'(ptca_pkg::DEPTH)) begin
            walk_res = ptca_pkg::WK_LONG;
        end else begin
            walk_res = ptca_pkg::WK_MOVE;
        end
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            ptca_pkg::RD_SCAN:   rd_addr = r_cnt[ptca_pkg::IDX_W-1:0];
            ptca_pkg::RD_START:  rd_addr = i_cmd.walk_sel ? r_s2 : r_s1;
            ptca_pkg::RD_PARENT: rd_addr = par_w[ptca_pkg::IDX_W-1:0];
            default:             rd_addr = r_cnt[ptca_pkg::IDX_W-1:0];
        endcase
    end

    assign n1_m1   = r_n1 - 1'b1;
    assign n2_m1   = r_n2 - 1'b1;
    assign k1_m1   = r_k1 - 1'b1;
    assign k2_m1   = r_k2 - 1'b1;
    assign p1_addr = i_cmd.cmp_start ? n1_m1[ptca_pkg::IDX_W-1:0] : k1_m1;
    assign p2_addr = i_cmd.cmp_start ? n2_m1[ptca_pkg::IDX_W-1:0] : k2_m1;
    assign cmp_eq  = (r_p1 == r_p2);

    assign o_sts.scan_done  = (r_cnt == ptca_pkg::CNT_W'(ptca_pkg::DEPTH));
    assign o_sts.found_both = n_f1 & n_f2;
    assign o_sts.walk_res   = walk_res;
    assign o_sts.root_case  = (r_n1 == '0) || (r_n2 == '0);
    assign o_sts.cmp_diff   = r_cfirst && !cmp_eq;
    assign o_sts.cmp_more   = cmp_eq && (r_k1 != '0) && (r_k2 != '0);

    // Table memory: one write port for entry loads, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry && wr_ok) begin
            r_slot_pid[wr_addr]    <= i_entry_pid;
            r_slot_parent[wr_addr] <= i_entry_parent;
        end
        r_rd_pid <= r_slot_pid[rd_addr];
        r_rd_par <= r_slot_parent[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_live <= '0;
        end else if (i_cmd.wr_entry && wr_ok) begin
            r_slot_live[wr_addr] <= i_entry_in_use;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_live <= r_slot_live[rd_addr];
    end

    // Chain memories: written during the walks, read back from the root end.
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_step && !r_first && !i_cmd.walk_sel) begin
            r_first_path[r_n[ptca_pkg::IDX_W-1:0]] <= r_rd_pid;
        end
        r_p1 <= r_first_path[p1_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_step && !r_first && i_cmd.walk_sel) begin
            r_second_path[r_n[ptca_pkg::IDX_W-1:0]] <= r_rd_pid;
        end
        r_p2 <= r_second_path[p2_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_q1  <= i_first_pid;
            r_q2  <= i_second_pid;
            r_cnt <= '0;
            r_f1  <= 1'b0;
            r_f2  <= 1'b0;
            r_anc <= '0;
        end
        if (i_cmd.scan_step) begin
            r_cnt <= r_cnt + 1'b1;
            r_f1  <= n_f1;
            r_f2  <= n_f2;
            if (hit1) begin
                r_s1 <= ev_idx;
            end
            if (hit2) begin
                r_s2 <= ev_idx;
            end
        end
        if (i_cmd.walk_start) begin
            r_cur   <= i_cmd.walk_sel ? r_s2 : r_s1;
            r_first <= 1'b1;
            r_n     <= '0;
        end
        if (i_cmd.walk_step) begin
            r_n     <= n_eff;
            r_first <= 1'b0;
            if (walk_res == ptca_pkg::WK_MOVE) begin
                r_cur <= par_w[ptca_pkg::IDX_W-1:0];
            end
            if (walk_res == ptca_pkg::WK_ROOT) begin
                if (i_cmd.walk_sel) begin
                    r_n2 <= n_eff;
                end else begin
                    r_n1 <= n_eff;
                end
            end
        end
        if (i_cmd.cmp_start) begin
            r_k1     <= n1_m1[ptca_pkg::IDX_W-1:0];
            r_k2     <= n2_m1[ptca_pkg::IDX_W-1:0];
            r_cfirst <= 1'b1;
        end
        if (i_cmd.cmp_step) begin
            r_k1     <= k1_m1;
            r_k2     <= k2_m1;
            r_cfirst <= 1'b0;
            if (cmp_eq) begin
                r_anc <= r_p1;
            end
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status_code;
        end
    end

    assign o_status       = r_status;
    assign o_ancestor_pid = (r_status == ptca_pkg::STS_FOUND) ? r_anc : '0;

endmodule

`default_nettype wire

FILE: sv/ptca_chk.sv
// Port-level checker for the process-table common-ancestor block, bound to the top level.
// Depends on ptca_pkg.
`default_nettype none

module ptca_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       s_axis_tuser,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [ptca_pkg::OUT_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Result beat dropped before it was taken.");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("Input accepted while a result is pending.");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("Input still ready after a query beat.");

    a_anc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] != ptca_pkg::STS_FOUND)
        |-> (m_axis_tdata[17:3] == '0))
        else $error("Ancestor pid is not zero on an error status.");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= ptca_pkg::STS_LONG))
        else $error("Status code out of range.");

endmodule

bind process_table_common_ancestor ptca_chk u_ptca_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: dv/process_table_common_ancestor_test.sv
// Self-checking testbench for the process-table common-ancestor block: streams table writes
// and ancestor queries, predicts every result from its own copy of the table and checks them.
// Depends on ptca_pkg and process_table_common_ancestor.
`timescale 1ns / 1ps

module process_table_common_ancestor_test;

    localparam bit ACT_WRITE = 1'b0;
    localparam bit ACT_QUERY = 1'b1;
    localparam int RANDOM_ITEMS = 750;
    localparam int DRAIN_CYCLES = 64;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef logic [ptca_pkg::PID_W-1:0] t_pid;
    typedef logic [ptca_pkg::PAR_W-1:0] t_slot;

    typedef struct packed {
        logic  action;
        t_slot entry_index;
        t_pid  entry_pid;
        t_slot entry_parent;
        logic  entry_in_use;
        t_pid  first_pid;
        t_pid  second_pid;
    } t_item;

    typedef struct packed {
        ptca_pkg::t_status status;
        t_pid              ancestor_pid;
    } t_answer;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [ptca_pkg::IN_W-1:0]  s_axis_tdata = '0;
    logic                       s_axis_tuser = 1'b0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [ptca_pkg::OUT_W-1:0] m_axis_tdata;

    // Table copy used by the predictor, updated as write beats are accepted.
    bit [ptca_pkg::PID_W-1:0]   tbl_pid [ptca_pkg::DEPTH];
    bit [ptca_pkg::PAR_W-1:0]   tbl_par [ptca_pkg::DEPTH];
    bit                         tbl_live [ptca_pkg::DEPTH];
    bit [ptca_pkg::PID_W-1:0]   chain_a [ptca_pkg::DEPTH];
    bit [ptca_pkg::PID_W-1:0]   chain_b [ptca_pkg::DEPTH];

    // Table copy used while building the stimulus, so that chains never leave written slots.
    bit [ptca_pkg::PID_W-1:0]   gen_pid [ptca_pkg::DEPTH];
    bit [ptca_pkg::PAR_W-1:0]   gen_par [ptca_pkg::DEPTH];
    bit                         gen_live [ptca_pkg::DEPTH];
    bit                         gen_written [ptca_pkg::DEPTH];
    int                         gen_slots [$];

    t_item             pending [$];
    t_answer           ancestor_due [$];
    t_item             cur_item;
    t_answer           got;
    t_answer           want;
    int                total_beats;
    int                beats_sent = 0;
    int                results_seen = 0;
    int                fail_count = 0;
    int                gap_left = 0;
    int                stall_left = 0;
    int                draw;
    longint            cycles = 0;

    process_table_common_ancestor DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic ptca_pkg::t_status walk_up(input int start, input bit to_b,
                                                  output int len);
        int                cur;
        int                n;
        ptca_pkg::t_status st;
        cur = start;
        n = 0;
        st = ptca_pkg::STS_FOUND;
        while (int'(tbl_par[cur]) != cur && st == ptca_pkg::STS_FOUND) begin
            if (n >= ptca_pkg::DEPTH) begin
                st = ptca_pkg::STS_LONG;
            end else begin
                cur = int'(tbl_par[cur]);
                if (to_b) chain_b[n] = tbl_pid[cur];
                else chain_a[n] = tbl_pid[cur];
                n++;
            end
        end
        len = n;
        return st;
    endfunction

    function automatic t_answer lca_lookup(input t_pid p1, input t_pid p2);
        t_answer res;
        bit      f1;
        bit      f2;
        int      s1;
        int      s2;
        int      n1;
        int      n2;
        res = '0;
        f1 = 0;
        f2 = 0;
        s1 = 0;
        s2 = 0;
        n1 = 0;
        n2 = 0;
        for (int i = 0; i < ptca_pkg::DEPTH; i++) begin
            if (tbl_live[i] && tbl_pid[i] == p1) begin
                f1 = 1;
                s1 = i;
            end
            if (tbl_live[i] && tbl_pid[i] == p2) begin
                f2 = 1;
                s2 = i;
            end
        end
        if (!f1 || !f2) begin
            res.status = ptca_pkg::STS_MISSING;
        end else begin
            res.status = walk_up(s1, 1'b0, n1);
            if (res.status == ptca_pkg::STS_FOUND) res.status = walk_up(s2, 1'b1, n2);
            if (res.status == ptca_pkg::STS_FOUND) begin
                if (n1 == 0 || n2 == 0) begin
                    res.status = ptca_pkg::STS_ROOT;
                end else if (chain_a[n1-1] != chain_b[n2-1]) begin
                    res.status = ptca_pkg::STS_DIFFER;
                end else begin
                    while (n1 > 1 && n2 > 1 && chain_a[n1-2] == chain_b[n2-2]) begin
                        n1--;
                        n2--;
                    end
                    res.ancestor_pid = chain_a[n1-1];
                end
            end
        end
        return res;
    endfunction

    function automatic void add_write(input int idx, input t_pid pid, input int par,
                                      input bit live);
        t_item it;
        it.action       = ACT_WRITE;
        it.entry_index  = t_slot'(idx);
        it.entry_pid    = pid;
        it.entry_parent = t_slot'(par);
        it.entry_in_use = live;
        it.first_pid    = t_pid'($urandom);
        it.second_pid   = t_pid'($urandom);
        pending.push_back(it);
        if (!gen_written[idx]) gen_slots.push_back(idx);
        gen_written[idx] = 1;
        gen_pid[idx]     = pid;
        gen_par[idx]     = t_slot'(par);
        gen_live[idx]    = live;
    endfunction

    function automatic void add_query(input t_pid a, input t_pid b);
        t_item it;
        it.action       = ACT_QUERY;
        it.entry_index  = t_slot'($urandom);
        it.entry_pid    = t_pid'($urandom);
        it.entry_parent = t_slot'($urandom);
        it.entry_in_use = 1'($urandom);
        it.first_pid    = a;
        it.second_pid   = b;
        pending.push_back(it);
    endfunction

    function automatic t_pid rand_pid();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return t_pid'($urandom_range(0, 47));
        if (r < 90) return t_pid'($urandom);
        return (r < 95) ? t_pid'(0) : {ptca_pkg::PID_W{1'b1}};
    endfunction

    function automatic t_pid live_pid();
        int live_slots [$];
        for (int i = 0; i < ptca_pkg::DEPTH; i++) begin
            if (gen_live[i]) live_slots.push_back(i);
        end
        if (live_slots.size() == 0) return rand_pid();
        return gen_pid[live_slots[$urandom_range(0, live_slots.size() - 1)]];
    endfunction

    // Most writes that would close a loop are turned into roots; a few loops are let through.
    function automatic int guard_parent(input int idx, input int par);
        int cur;
        bit loops;
        cur = par;
        loops = 0;
        for (int k = 0; k <= ptca_pkg::DEPTH && cur != idx; k++) begin
            if (int'(gen_par[cur]) == cur) k = ptca_pkg::DEPTH + 1;
            else cur = int'(gen_par[cur]);
        end
        loops = (cur == idx) && (par != idx);
        if (loops && $urandom_range(0, 9) != 0) return idx;
        return par;
    endfunction

    function automatic int any_parent(input int idx);
        if (gen_slots.size() == 0) return idx;
        return gen_slots[$urandom_range(0, gen_slots.size() - 1)];
    endfunction

    initial begin
        int n;
        int r;
        int idx;
        int par;
        int base;
        int len;
        t_pid a;
        t_pid b;

        add_write(0, 15'd0, 0, 1);
        add_write(255, {ptca_pkg::PID_W{1'b1}}, 0, 1);
        add_write(1, 15'd5, 255, 1);
        add_write(2, 15'd6, 255, 1);
        add_write(3, 15'd7, 1, 1);
        add_write(10, 15'd100, 10, 1);
        add_write(11, 15'd101, 10, 1);
        add_query(15'd7, 15'd6);
        add_query(15'd7, 15'd7);
        add_query(15'd7, 15'd5);
        add_query(15'd0, 15'd7);
        add_query(15'd7, 15'd101);
        add_query(15'd9999, 15'd7);
        add_write(4, 15'd200, 1, 0);
        add_query(15'd200, 15'd7);
        add_write(5, 15'd201, 4, 1);
        add_query(15'd201, 15'd6);
        add_write(20, 15'd7, 11, 1);
        add_query(15'd7, 15'd101);
        add_write(31, 15'd301, 31, 1);
        add_write(30, 15'd300, 31, 1);
        add_write(31, 15'd301, 30, 1);
        add_query(15'd300, 15'd6);
        add_write(31, 15'd301, 31, 1);
        add_query(15'd300, 15'd300);
        add_query(15'd0, 15'd0);

        n = 0;
        while (n < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
                base = $urandom_range(0, 200);
                len = $urandom_range(8, 55);
                for (int k = 0; k < len; k++) begin
                    idx = base + k;
                    par = (k == 0) ? any_parent(idx) : idx - 1;
                    add_write(idx, rand_pid(), guard_parent(idx, par), 1);
                end
                n += len;
            end else if (r < ((n < 100) ? 80 : 40)) begin
                idx = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 39);
                r = $urandom_range(0, 99);
                if (r < 15) par = idx;
                else if (r < 30 && idx > 0 && gen_written[idx-1]) par = idx - 1;
                else par = any_parent(idx);
                add_write(idx, rand_pid(), guard_parent(idx, par), $urandom_range(0, 99) < 85);
                n++;
            end else begin
                a = ($urandom_range(0, 99) < 85) ? live_pid() : t_pid'($urandom);
                r = $urandom_range(0, 99);
                if (r < 15) b = a;
                else if (r < 85) b = live_pid();
                else b = t_pid'($urandom);
                add_query(a, b);
                n++;
            end
        end
        total_beats = pending.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(negedge i_clk); while (beats_sent != total_beats || ancestor_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (cur_item.action == ACT_WRITE) begin
                    tbl_pid[cur_item.entry_index]  = cur_item.entry_pid;
                    tbl_par[cur_item.entry_index]  = cur_item.entry_parent;
                    tbl_live[cur_item.entry_index] = cur_item.entry_in_use;
                end else begin
                    ancestor_due.push_back(lca_lookup(cur_item.first_pid, cur_item.second_pid));
                end
                beats_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending.size() != 0) begin
                    cur_item = pending.pop_front();
                    s_axis_tdata <= {2'b00, cur_item.second_pid, cur_item.first_pid,
                                     cur_item.entry_in_use, cur_item.entry_parent,
                                     cur_item.entry_pid, cur_item.entry_index};
                    s_axis_tuser <= cur_item.action;
                    s_axis_tvalid <= 1'b1;
                    gap_left <= ((beats_sent / 50) % 4 == 3) ? 0 : $urandom_range(0, 7);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tdata[ptca_pkg::STS_W-1:0];
            got.ancestor_pid = m_axis_tdata[ptca_pkg::STS_W +: ptca_pkg::PID_W];
            results_seen++;
            if (ancestor_due.size() == 0) begin
                $error("result beat with no query outstanding: status %0d ancestor_pid %0d",
                       got.status, got.ancestor_pid);
                fail_count++;
            end else begin
                want = ancestor_due.pop_front();
                if (got.status != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.ancestor_pid != want.ancestor_pid) begin
                    $error("ancestor_pid: expected %0d, got %0d",
                           want.ancestor_pid, got.ancestor_pid);
                    fail_count++;
                end
            end
            draw = ((results_seen / 40) % 4 == 3) ? 0 : $urandom_range(0, 7);
            stall_left <= draw;
            m_axis_tready <= (draw == 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
